FILE: rtl/dst_region_rule_check_assert.svh
// assertion macros for the daylight saving rule checker
// used by the top level only, no other dependencies
`ifndef DST_REGION_RULE_CHECK_ASSERT_SVH
`define DST_REGION_RULE_CHECK_ASSERT_SVH

`ifndef SYNTHESIS
`define DRC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication failed");
`define DRC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication failed");
`else
`define DRC_ASSERT_IMP(label, clk, rst_n, pre, post)
`define DRC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

FILE: rtl/drc_pkg.sv
// shared types, constants and calendar functions of the dst rule checker
// no dependencies
package drc_pkg;

    localparam int YEAR_W     = 12;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int REGION_W   = 3;
    localparam int OFFSET_W   = 11;
    localparam int MINUTES_W  = 21;
    localparam int RELDAY_W   = 11;
    localparam int TOD_W      = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // floor(y / 100) as (y * CENT_RECIP) >> CENT_SHIFT, exact for 12-bit years
    localparam int CENT_RECIP     = 5243;
    localparam int CENT_SHIFT     = 19;
    localparam int CENT_PROD_W    = 25;
    localparam int CENT_W         = 6;
    localparam int YEARS_PER_CENT = 100;
    localparam int WSUM_W         = 13;
    localparam int MAR1_DOW_BIAS  = 3;
    localparam int MIN_PER_DAY    = 1440;
    localparam int MIN_PER_HOUR   = 60;
    localparam int DAYS_PER_YEAR  = 365;

    typedef enum logic [REGION_W-1:0] {
        REGION_EUROPE      = 3'd0,
        REGION_USA         = 3'd1,
        REGION_AUSTRALIA   = 3'd2,
        REGION_NEW_ZEALAND = 3'd3,
        REGION_EGYPT       = 3'd4
    } drc_region_t;

    typedef enum logic [0:0] {
        REG_REGION_RULE     = 1'b0,
        REG_STANDARD_OFFSET = 1'b1
    } drc_reg_index_t;

    typedef struct packed {
        logic [REGION_W-1:0]        region;
        logic signed [OFFSET_W-1:0] offset;
    } drc_cfg_t;

    typedef struct packed {
        logic [8:0]              start_day;
        logic [8:0]              end_day;
        logic signed [TOD_W-1:0] start_tod;
        logic signed [TOD_W-1:0] end_tod;
        logic                    use_offset;
        logic                    southern;
        logic                    no_rule;
    } drc_rule_t;

    typedef struct packed {
        logic signed [MINUTES_W-1:0] now_min;
        logic signed [MINUTES_W-1:0] start_min;
        logic signed [MINUTES_W-1:0] end_min;
        logic                        southern;
        logic                        no_rule;
    } drc_work_t;

    typedef struct packed {
        logic empty;
        logic full;
    } drc_qstat_t;

    // march-based day of year of day 1, months past december roll on linearly
    function automatic logic [8:0] month_base(input logic [MONTH_W-1:0] m);
        logic [8:0] b;
        unique case (m)
            4'd0:  b = 9'd306;
            4'd1:  b = 9'd337;
            4'd2:  b = 9'd0;
            4'd3:  b = 9'd31;
            4'd4:  b = 9'd61;
            4'd5:  b = 9'd92;
            4'd6:  b = 9'd122;
            4'd7:  b = 9'd153;
            4'd8:  b = 9'd184;
            4'd9:  b = 9'd214;
            4'd10: b = 9'd245;
            4'd11: b = 9'd275;
            4'd12: b = 9'd306;
            4'd13: b = 9'd337;
            4'd14: b = 9'd367;
            4'd15: b = 9'd398;
        endcase
        return b;
    endfunction

    // residue mod 7 by folding octal digits, 8 = 1 mod 7
    function automatic logic [2:0] mod7_fold(input logic [WSUM_W-1:0] x);
        logic [4:0] a;
        logic [3:0] b;
        a = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[11:9]) + 5'(x[12]);
        b = 4'(a[2:0]) + 4'(a[4:3]);
        return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
    endfunction

    function automatic logic [2:0] mod7_add(input logic [2:0] w, input logic [2:0] c);
        logic [3:0] s;
        s = 4'(w) + 4'(c);
        return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
    endfunction

    // days forward from a weekday to the next sunday
    function automatic logic [2:0] to_sunday(input logic [2:0] k);
        return (k == 3'd0) ? 3'd0 : 3'(4'd7 - 4'(k));
    endfunction

    // transition days relative to march 1, w is the weekday of march 1
    function automatic drc_rule_t rule_lookup(input logic [REGION_W-1:0] region,
                                              input logic [2:0] w);
        drc_rule_t r;
        r = '0;
        unique case (region)
            REGION_EUROPE: begin
                r.start_day = 9'd30 - 9'(mod7_add(w, 3'd2));
                r.end_day   = 9'd244 - 9'(mod7_add(w, 3'd6));
                r.start_tod = 11'sd60;
                r.end_tod   = 11'sd60;
            end
            REGION_USA: begin
                r.start_day  = 9'd7 + 9'(to_sunday(w));
                r.end_day    = 9'd245 + 9'(to_sunday(w));
                r.start_tod  = 11'sd120;
                r.end_tod    = 11'sd60;
                r.use_offset = 1'b1;
            end
            REGION_AUSTRALIA: begin
                r.start_day  = 9'd214 + 9'(to_sunday(mod7_add(w, 3'd4)));
                r.end_day    = 9'd31 + 9'(to_sunday(mod7_add(w, 3'd3)));
                r.start_tod  = 11'sd120;
                r.end_tod    = 11'sd120;
                r.use_offset = 1'b1;
                r.southern   = 1'b1;
            end
            REGION_NEW_ZEALAND: begin
                r.start_day  = 9'd213 - 9'(mod7_add(w, 3'd3));
                r.end_day    = 9'd31 + 9'(to_sunday(mod7_add(w, 3'd3)));
                r.start_tod  = 11'sd120;
                r.end_tod    = 11'sd120;
                r.use_offset = 1'b1;
                r.southern   = 1'b1;
            end
            REGION_EGYPT: begin
                r.start_day = 9'd60 - 9'(mod7_add(w, 3'd6));
                r.end_day   = 9'd244 - 9'(mod7_add(w, 3'd1));
                r.start_tod = -11'sd120;
                r.end_tod   = -11'sd180;
            end
            default: begin
                r.no_rule = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/drc_if.sv
// item channels of the dst rule checker: utc timestamp in, verdict out
// depends on drc_pkg
interface drc_sample_if;
    import drc_pkg::*;

    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year_number;
    logic [MONTH_W-1:0]  month_index;
    logic [DAY_W-1:0]    day_of_month;
    logic [HOUR_W-1:0]   hour_of_day;
    logic [MINUTE_W-1:0] minute_of_hour;

    modport source (
        output valid, year_number, month_index, day_of_month, hour_of_day, minute_of_hour,
        input  ready
    );
    modport sink (
        input  valid, year_number, month_index, day_of_month, hour_of_day, minute_of_hour,
        output ready
    );
endinterface

interface drc_result_if;
    logic valid;
    logic ready;
    logic dst_active;

    modport source (output valid, dst_active, input ready);
    modport sink (input valid, dst_active, output ready);
endinterface

FILE: rtl/dst_region_rule_check.sv
// daylight saving rule checker, top level
// path from sample acceptance to result valid: capture, then three front stages
// (weekday and leap, relative day, minute math), the queue and the registered compare
// stage; throughput one item per cycle unless result.ready back-pressure stalls the flow
// a two-item queue and the result register keep items moving under stalls
// reset (asynchronous, active low) empties the pipeline and clears both registers
`include "dst_region_rule_check_assert.svh"

module dst_region_rule_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [drc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [drc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [drc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    drc_sample_if.sink                     sample,
    drc_result_if.source                   result
);
    import drc_pkg::*;

    drc_cfg_t   cfg;
    drc_work_t  front_work;
    drc_work_t  head;
    drc_qstat_t qstat;
    logic       front_push;
    logic       back_pop;

    drc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    drc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .cfg    (cfg),
        .full   (qstat.full),
        .push   (front_push),
        .work   (front_work)
    );

    drc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_data (front_work),
        .pop     (back_pop),
        .rd_data (head),
        .stat    (qstat)
    );

    drc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .stat   (qstat),
        .pop    (back_pop),
        .result (result)
    );

    `DRC_ASSERT_IMP(a_unknown_region_off, clk, rst_n,
        result.valid && (cfg.region > REGION_EGYPT), !result.dst_active)
    `DRC_ASSERT_IMP(a_result_from_queue, clk, rst_n, $rose(result.valid), $past(!qstat.empty))
    `DRC_ASSERT_NEXT(a_queue_drains, clk, rst_n, !qstat.empty && !result.valid, result.valid)

endmodule

FILE: rtl/drc_cfg.sv
// apb register file: region rule and standard offset
// depends on drc_pkg
module drc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [drc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [drc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [drc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output drc_pkg::drc_cfg_t              cfg
);
    import drc_pkg::*;

    logic [REGION_W-1:0]        region_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic                       wr_en;
    drc_reg_index_t             index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign index  = drc_reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= '0;
            offset_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_REGION_RULE:     region_reg <= pwdata[REGION_W-1:0];
                REG_STANDARD_OFFSET: offset_reg <= $signed(pwdata[OFFSET_W-1:0]);
                default:             region_reg <= region_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_REGION_RULE:     prdata = APB_DATA_W'(region_reg);
            REG_STANDARD_OFFSET: prdata = APB_DATA_W'(offset_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.region = region_reg;
    assign cfg.offset = offset_reg;

endmodule

FILE: rtl/drc_front.sv
// front pipeline: timestamp to minutes from march 1 and rule transitions
// depends on drc_pkg and drc_if
module drc_front (
    input  logic                clk,
    input  logic                rst_n,
    drc_sample_if.sink          sample,
    input  drc_pkg::drc_cfg_t   cfg,
    input  logic                full,
    output logic                push,
    output drc_pkg::drc_work_t  work
);
    import drc_pkg::*;

    // stage 1: captured fields and century count
    logic                s1_valid_reg;
    logic [YEAR_W-1:0]   s1_year_reg;
    logic [MONTH_W-1:0]  s1_month_reg;
    logic [DAY_W-1:0]    s1_day_reg;
    logic [HOUR_W-1:0]   s1_hour_reg;
    logic [MINUTE_W-1:0] s1_min_reg;
    logic [CENT_W-1:0]   s1_cent_reg;
    // stage 2: weekday sum, leap flag, day of march-based year
    logic                       s2_valid_reg;
    logic [WSUM_W-1:0]          s2_wsum_reg;
    logic                       s2_leap_reg;
    logic                       s2_jan_feb_reg;
    logic signed [RELDAY_W-1:0] s2_relpre_reg;
    logic [TOD_W-1:0]           s2_hm_reg;
    // stage 3: weekday of march 1 and day relative to march 1
    logic                       s3_valid_reg;
    logic [2:0]                 s3_wday_reg;
    logic signed [RELDAY_W-1:0] s3_rel_reg;
    logic [TOD_W-1:0]           s3_hm_reg;
    // stage 4: minutes of now and both transitions
    logic                       s4_valid_reg;
    drc_work_t                  s4_work_reg;

    logic rdy1, rdy2, rdy3, rdy4;

    logic [CENT_PROD_W-1:0]     cent_prod;
    logic [YEAR_W-1:0]          rem100;
    logic                       rem_zero;
    logic                       leap;
    logic [WSUM_W-1:0]          wsum;
    logic signed [RELDAY_W-1:0] relpre;
    logic [TOD_W-1:0]           hm;
    logic signed [RELDAY_W-1:0] year_len;
    drc_rule_t                  rule;
    drc_work_t                  work_next;

    assign rdy4 = !s4_valid_reg || !full;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;
    assign sample.ready = rdy1;
    assign push = s4_valid_reg && !full;
    assign work = s4_work_reg;

    assign cent_prod = CENT_PROD_W'(sample.year_number) * CENT_PROD_W'(CENT_RECIP);

    assign rem100   = s1_year_reg - YEAR_W'(s1_cent_reg) * YEAR_W'(YEARS_PER_CENT);
    assign rem_zero = (rem100 == '0);
    assign leap     = ((s1_year_reg[1:0] == 2'd0) && !rem_zero)
                   || (rem_zero && (s1_cent_reg[1:0] == 2'd0));
    assign wsum     = WSUM_W'(s1_year_reg) + WSUM_W'(s1_year_reg[YEAR_W-1:2])
                    - WSUM_W'(s1_cent_reg) + WSUM_W'(s1_cent_reg[CENT_W-1:2])
                    + WSUM_W'(MAR1_DOW_BIAS);
    assign relpre   = $signed(RELDAY_W'(month_base(s1_month_reg)))
                    + $signed(RELDAY_W'(s1_day_reg)) - RELDAY_W'(1);
    assign hm       = TOD_W'(s1_hour_reg) * TOD_W'(MIN_PER_HOUR) + TOD_W'(s1_min_reg);

    // january and february belong to the march-based year before
    assign year_len = $signed(RELDAY_W'(DAYS_PER_YEAR)) + $signed(RELDAY_W'(s2_leap_reg));

    assign rule = rule_lookup(cfg.region, s3_wday_reg);

    always_comb
    begin
        work_next.now_min   = MINUTES_W'(s3_rel_reg) * MINUTES_W'(MIN_PER_DAY)
                            + $signed(MINUTES_W'(s3_hm_reg));
        work_next.start_min = $signed(MINUTES_W'(rule.start_day)) * MINUTES_W'(MIN_PER_DAY)
                            + MINUTES_W'(rule.start_tod)
                            - (rule.use_offset ? MINUTES_W'(cfg.offset) : '0);
        work_next.end_min   = $signed(MINUTES_W'(rule.end_day)) * MINUTES_W'(MIN_PER_DAY)
                            + MINUTES_W'(rule.end_tod)
                            - (rule.use_offset ? MINUTES_W'(cfg.offset) : '0);
        work_next.southern  = rule.southern;
        work_next.no_rule   = rule.no_rule;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= sample.valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy4)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && sample.valid)
        begin
            s1_year_reg  <= sample.year_number;
            s1_month_reg <= sample.month_index;
            s1_day_reg   <= sample.day_of_month;
            s1_hour_reg  <= sample.hour_of_day;
            s1_min_reg   <= sample.minute_of_hour;
            s1_cent_reg  <= cent_prod[CENT_SHIFT +: CENT_W];
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_wsum_reg    <= wsum;
            s2_leap_reg    <= leap;
            s2_jan_feb_reg <= (s1_month_reg[MONTH_W-1:1] == '0);
            s2_relpre_reg  <= relpre;
            s2_hm_reg      <= hm;
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_wday_reg <= mod7_fold(s2_wsum_reg);
            s3_rel_reg  <= s2_jan_feb_reg ? (s2_relpre_reg - year_len) : s2_relpre_reg;
            s3_hm_reg   <= s2_hm_reg;
        end
        if (rdy4 && s3_valid_reg)
            s4_work_reg <= work_next;
    end

endmodule

FILE: rtl/drc_queue.sv
// short queue between the front pipeline and the compare stage
// depends on drc_pkg
module drc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  drc_pkg::drc_work_t  wr_data,
    input  logic                pop,
    output drc_pkg::drc_work_t  rd_data,
    output drc_pkg::drc_qstat_t stat
);
    import drc_pkg::*;

    drc_work_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                       : wr_ptr_reg + QUEUE_PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                       : rd_ptr_reg + QUEUE_PTR_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data    = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule

FILE: rtl/drc_back.sv
// compare stage: window test against the transitions, registered result
// depends on drc_pkg and drc_if
module drc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  drc_pkg::drc_work_t  head,
    input  drc_pkg::drc_qstat_t stat,
    output logic                pop,
    drc_result_if.source        result
);
    import drc_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic active_reg;
    logic take;
    logic after_start;
    logic before_end;
    logic active;

    assign take           = !out_valid_reg || result.ready;
    assign pop            = take && !stat.empty;
    assign out_valid_next = take ? !stat.empty : out_valid_reg;

    assign after_start = (head.now_min >= head.start_min);
    assign before_end  = (head.now_min < head.end_min);

    always_comb
    begin
        if (head.no_rule)
            active = 1'b0;
        else if (head.southern)
            active = before_end || after_start;
        else
            active = after_start && before_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            active_reg <= active;
    end

    assign result.valid      = out_valid_reg;
    assign result.dst_active = active_reg;

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench of dst_region_rule_check: random utc timestamps under many region
// and offset settings, each verdict compared with a calendar model kept in a small class
// depends on drc_pkg, drc_if.sv and the dst_region_rule_check rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import drc_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int N_PHASES        = 20;
    localparam int N_FIXED         = 16;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 400000;

    localparam longint ERA_DAYS    = 146097;
    localparam longint EPOCH_SHIFT = 719468;
    localparam longint LOCAL_2AM   = 120;
    localparam longint LOCAL_3AM   = 180;
    localparam longint DST_SHIFT   = 60;
    localparam longint EGYPT_STD   = 120;
    localparam longint EGYPT_DST   = 180;

    localparam longint FEBRUARY  = 1;
    localparam longint MARCH     = 2;
    localparam longint APRIL     = 3;
    localparam longint SEPTEMBER = 8;
    localparam longint OCTOBER   = 9;
    localparam longint NOVEMBER  = 10;
    localparam longint SUNDAY    = 0;
    localparam longint FRIDAY    = 5;

    // region codes with no rule behind them
    localparam logic [REGION_W-1:0] REGION_SPARE_A = 3'd5;
    localparam logic [REGION_W-1:0] REGION_SPARE_B = 3'd6;
    localparam logic [REGION_W-1:0] REGION_SPARE_C = 3'd7;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } utc_stamp_t;

    class dst_verdict_book;
        logic [REGION_W-1:0]        region = '0;
        logic signed [OFFSET_W-1:0] offset = '0;
        bit                         pending_verdicts[$];
        int                         failures = 0;
        int                         checked = 0;
        int                         active_seen = 0;

        function void set_register(drc_reg_index_t idx, logic [31:0] value);
            if (idx == REG_REGION_RULE)
                region = value[REGION_W-1:0];
            else
                offset = value[OFFSET_W-1:0];
        endfunction

        function longint civil_days(longint y, longint m, longint d);
            longint yy, era, yoe, mp, doy, doe;
            yy = (m <= FEBRUARY) ? y - 1 : y;
            era = (yy >= 0 ? yy : yy - 399) / 400;
            yoe = yy - era * 400;
            mp = (m > FEBRUARY) ? m - 2 : m + 10;
            doy = (153 * mp + 2) / 5 + d - 1;
            doe = yoe * DAYS_PER_YEAR + yoe / 4 - yoe / 100 + doy;
            return era * ERA_DAYS + doe - EPOCH_SHIFT;
        endfunction

        function longint weekday(longint y, longint m, longint d);
            longint r;
            r = (civil_days(y, m, d) + 4) % 7;
            return (r < 0) ? r + 7 : r;
        endfunction

        function longint days_in(longint y, longint m);
            bit leap;
            leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
            case (m)
                FEBRUARY: return leap ? 29 : 28;
                APRIL, 5, SEPTEMBER, NOVEMBER: return 30;
                default: return 31;
            endcase
        endfunction

        function longint nth_sunday(longint y, longint m, longint n);
            return 1 + (7 - weekday(y, m, 1)) % 7 + (n - 1) * 7;
        endfunction

        function longint last_weekday(longint y, longint m, longint wd);
            longint last;
            last = days_in(y, m);
            return last - (weekday(y, m, last) - wd + 7) % 7;
        endfunction

        // month, day and utc minute of day of the switch into or out of dst
        function void rule_edge(input longint y, input bit begins, output longint m,
                                output longint d, output longint tod);
            longint off;
            off = longint'(offset);
            case (region)
                REGION_USA:
                begin
                    m   = begins ? MARCH : NOVEMBER;
                    d   = nth_sunday(y, m, begins ? 2 : 1);
                    tod = begins ? LOCAL_2AM - off : LOCAL_2AM - (off + DST_SHIFT);
                end
                REGION_AUSTRALIA, REGION_NEW_ZEALAND:
                begin
                    if (!begins)
                    begin
                        m   = APRIL;
                        d   = nth_sunday(y, APRIL, 1);
                        tod = LOCAL_3AM - (off + DST_SHIFT);
                    end
                    else if (region == REGION_AUSTRALIA)
                    begin
                        m   = OCTOBER;
                        d   = nth_sunday(y, OCTOBER, 1);
                        tod = LOCAL_2AM - off;
                    end
                    else
                    begin
                        m   = SEPTEMBER;
                        d   = last_weekday(y, SEPTEMBER, SUNDAY);
                        tod = LOCAL_2AM - off;
                    end
                end
                REGION_EGYPT:
                begin
                    m   = begins ? APRIL : OCTOBER;
                    d   = last_weekday(y, m, FRIDAY);
                    tod = begins ? -EGYPT_STD : -EGYPT_DST;
                end
                default:
                begin
                    m   = begins ? MARCH : OCTOBER;
                    d   = last_weekday(y, m, SUNDAY);
                    tod = DST_SHIFT;
                end
            endcase
        endfunction

        function bit predict_dst(utc_stamp_t s);
            longint y, now, sm, sd, st, em, ed, et, t_start, t_end;
            y = longint'(s.year);
            now = civil_days(y, longint'(s.month), longint'(s.day)) * MIN_PER_DAY
                + longint'(s.hour) * MIN_PER_HOUR + longint'(s.minute);
            if (region > REGION_EGYPT)
                return 1'b0;
            rule_edge(y, 1'b1, sm, sd, st);
            rule_edge(y, 1'b0, em, ed, et);
            t_start = civil_days(y, sm, sd) * MIN_PER_DAY + st;
            t_end = civil_days(y, em, ed) * MIN_PER_DAY + et;
            if (region == REGION_AUSTRALIA || region == REGION_NEW_ZEALAND)
                return now < t_end || now >= t_start;
            return now >= t_start && now < t_end;
        endfunction

        function void note_timestamp(utc_stamp_t s);
            pending_verdicts.push_back(predict_dst(s));
        endfunction

        function void check_verdict(logic got);
            bit want;
            if (pending_verdicts.size() == 0)
            begin
                $error("dst_active: no result expected, actual %0b", got);
                failures++;
                return;
            end
            want = pending_verdicts.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("dst_active: expected %0b, actual %0b", want, got);
                failures++;
            end
            else if (want)
                active_seen++;
        endfunction

        function void close_out();
            if (pending_verdicts.size() != 0)
            begin
                $error("dst_active: %0d expected results never arrived", pending_verdicts.size());
                failures++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    cycles = 0;
    int                    src_calm = 0;
    int                    dst_calm = 0;
    dst_verdict_book       book = new;

    drc_sample_if sample_ch ();
    drc_result_if result_ch ();

    dst_region_rule_check u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .result  (result_ch)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    logic [REGION_W-1:0] phase_region [N_FIXED] = '{
        REGION_EUROPE, REGION_USA, REGION_AUSTRALIA, REGION_NEW_ZEALAND,
        REGION_EGYPT, REGION_USA, REGION_AUSTRALIA, REGION_NEW_ZEALAND,
        REGION_EUROPE, REGION_USA, REGION_AUSTRALIA, REGION_NEW_ZEALAND,
        REGION_EGYPT, REGION_SPARE_A, REGION_SPARE_B, REGION_SPARE_C
    };
    int phase_offset [N_FIXED] = '{0, -1024, 1023, -720, 840, 840, -720, 1023,
                                   -1024, -300, 600, -1024, 1023, 0, -600, 840};

    utc_stamp_t directed_stamps [] = '{
        '{0, 0, 1, 0, 0},
        '{0, 0, 0, 0, 0},
        '{4095, 15, 31, 31, 63},
        '{1900, 0, 1, 0, 0},
        '{2000, 1, 29, 12, 30},
        '{2100, 12, 1, 0, 0},
        '{1999, 13, 0, 0, 0},
        '{2024, 2, 31, 0, 59},
        '{2024, 2, 31, 1, 0},
        '{2024, 9, 27, 0, 59},
        '{2024, 9, 27, 1, 0},
        '{2023, 6, 15, 12, 0},
        '{3000, 11, 31, 23, 59},
        '{2047, 7, 16, 21, 42},
        '{2048, 14, 15, 16, 33}
    };

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic utc_stamp_t near_edge_stamp();
        longint     y, m, d, tod, mins;
        utc_stamp_t s;
        y = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 4095))
                                        : longint'($urandom_range(1900, 2200));
        book.rule_edge(y, 1'($urandom_range(0, 1)), m, d, tod);
        if ($urandom_range(0, 2) == 0)
            mins = tod + longint'($urandom_range(0, 2)) - 1;
        else
            mins = tod + longint'($urandom_range(0, 240)) - 120;
        if (mins < 0)
        begin
            d--;
            mins += MIN_PER_DAY;
        end
        s.year   = YEAR_W'(y);
        s.month  = MONTH_W'(m);
        s.day    = DAY_W'(d);
        s.hour   = HOUR_W'(mins / MIN_PER_HOUR);
        s.minute = MINUTE_W'(mins % MIN_PER_HOUR);
        return s;
    endfunction

    function automatic utc_stamp_t random_stamp();
        utc_stamp_t s;
        int         kind;
        kind = $urandom_range(0, 9);
        if (kind < 5)
            return near_edge_stamp();
        if (kind < 8)
        begin
            s.year   = YEAR_W'($urandom_range(1900, 4095));
            s.month  = MONTH_W'($urandom_range(0, 11));
            s.day    = DAY_W'($urandom_range(1, 31));
            s.hour   = HOUR_W'($urandom_range(0, 23));
            s.minute = MINUTE_W'($urandom_range(0, 59));
        end
        else
            s = $urandom();
        return s;
    endfunction

    task automatic write_register(input drc_reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        book.set_register(idx, value);
    endtask

    task automatic send_stamp(input utc_stamp_t s);
        int gap;
        gap = draw_wait(src_calm);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.year_number    <= s.year;
        sample_ch.month_index    <= s.month;
        sample_ch.day_of_month   <= s.day;
        sample_ch.hour_of_day    <= s.hour;
        sample_ch.minute_of_hour <= s.minute;
        do @(posedge clk); while (!sample_ch.ready);
        book.note_timestamp(s);
    endtask

    initial
    begin
        int gap;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_wait(dst_calm);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            book.check_verdict(result_ch.dst_active);
        end
    end

    initial
    begin
        logic [31:0]                value;
        logic [REGION_W-1:0]        region;
        logic signed [OFFSET_W-1:0] offset;
        rst_n                    <= 1'b0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        sample_ch.valid          <= 1'b0;
        sample_ch.year_number    <= '0;
        sample_ch.month_index    <= '0;
        sample_ch.day_of_month   <= '0;
        sample_ch.hour_of_day    <= '0;
        sample_ch.minute_of_hour <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p < N_FIXED)
            begin
                region = phase_region[p];
                offset = OFFSET_W'(phase_offset[p]);
            end
            else
            begin
                region = REGION_W'($urandom_range(0, 7));
                offset = OFFSET_W'($urandom());
            end
            value = $urandom();
            value[REGION_W-1:0] = region;
            write_register(REG_REGION_RULE, value);
            value = $urandom();
            value[OFFSET_W-1:0] = offset;
            write_register(REG_STANDARD_OFFSET, value);
            if (p == 0)
                foreach (directed_stamps[i])
                    send_stamp(directed_stamps[i]);
            repeat (ITEMS_PER_PHASE) send_stamp(random_stamp());
            sample_ch.valid <= 1'b0;
            while (book.pending_verdicts.size() != 0) @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        book.close_out();

        $display("checked %0d timestamps over %0d region/offset settings, %0d in dst",
                 book.checked, N_PHASES, book.active_seen);
        $display("all region codes, full offset range, edge minutes and raw field values driven");
        if (book.failures == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
